FILE: rtl/hsoc_pkg.sv
// Shared types and constants for the heap sort block with operation counts.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package hsoc_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 16;
    localparam int SWAP_COPIES      = 3;
    localparam int COPY_STEP        = SWAP_COPIES + 1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } hsoc_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic [COUNT_W-1:0]        compare_total;
        logic [COUNT_W-1:0]        copy_total;
    } hsoc_out_t;

    // counter control from the sequencer
    typedef struct packed {
        logic       clear;
        logic [1:0] cmp_add;
        logic       copy_add;
    } hsoc_cnt_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLD_RD,
        ST_BLD_WAIT,
        ST_SFT_L,
        ST_SFT_R,
        ST_SFT_CMP,
        ST_SFT_END,
        ST_EXT_RD0,
        ST_EXT_RDJ,
        ST_EXT_WR,
        ST_EMIT
    } hsoc_state_t;

endpackage

`default_nettype wire

FILE: rtl/heap_sort_with_op_counts_top.sv
// Top level of the heap sort block: store, sequencer, counters, result register.
// Depends on hsoc_pkg, hsoc_store, hsoc_counts and hsoc_seq.
//
//   channel   ports                 handshake
//   request   start, busy, item     taken at a clock edge with start high and busy low
//   result    strobe, result        valid for the one cycle that strobe is high
//
// Loading takes one cycle per request; after the request flagged last the block is busy.
// Sort: each build node is fetched and sifted down; each extract moves the root to the heap end
// and sifts the last value from the root. A sift ends at a leaf or after a final compare.
// Emit takes one cycle per result; each result goes via the store read data and result registers.
// The receiver cannot stall results. Reset clears the control state; the store needs no clearing.
`default_nettype none

module heap_sort_with_op_counts_top #(
    parameter int MAX_ELEMENTS = hsoc_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire hsoc_pkg::hsoc_in_t  item,
    output logic                     strobe,
    output hsoc_pkg::hsoc_out_t      result
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic                                 we, re;
    logic [AW-1:0]                        waddr, raddr;
    logic signed [hsoc_pkg::VALUE_W-1:0]  wdata, rdata;
    hsoc_pkg::hsoc_cnt_ctl_t              cnt_ctl;
    logic [hsoc_pkg::COUNT_W-1:0]         compare_total, copy_total;
    logic                                 emit_valid, emit_last;

    hsoc_pkg::hsoc_out_t                  result_reg, result_next;
    logic                                 strobe_reg;

    hsoc_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    hsoc_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .re         (re),
        .raddr      (raddr),
        .rdata      (rdata),
        .cnt_ctl    (cnt_ctl),
        .emit_valid (emit_valid),
        .emit_last  (emit_last)
    );

    hsoc_counts u_counts (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (cnt_ctl),
        .compare_total (compare_total),
        .copy_total    (copy_total)
    );

    always_comb
    begin
        result_next = result_reg;
        if (emit_valid)
        begin
            result_next.sorted_value  = rdata;
            result_next.last_out      = emit_last;
            result_next.compare_total = compare_total;
            result_next.copy_total    = copy_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/hsoc_store.sv
// Element store: single write port, single read port, registered read data.
// Depends on hsoc_pkg for the element width.
`default_nettype none

module hsoc_store #(
    parameter int DEPTH = hsoc_pkg::MAX_ELEMENTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [AW-1:0]                     waddr,
    input  wire logic signed [hsoc_pkg::VALUE_W-1:0] wdata,
    input  wire logic                              re,
    input  wire logic [AW-1:0]                     raddr,
    output logic signed [hsoc_pkg::VALUE_W-1:0]    rdata
);

    logic signed [hsoc_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hsoc_counts.sv
// Saturating comparison and copy counters.
// Depends on hsoc_pkg for widths, the copy step and the control struct.
`default_nettype none

module hsoc_counts (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hsoc_pkg::hsoc_cnt_ctl_t       ctl,
    output logic [hsoc_pkg::COUNT_W-1:0]       compare_total,
    output logic [hsoc_pkg::COUNT_W-1:0]       copy_total
);

    localparam int CW = hsoc_pkg::COUNT_W;

    logic [CW-1:0] cmp_reg, cmp_next;
    logic [CW-1:0] cpy_reg, cpy_next;
    logic [CW:0]   cmp_sum, cpy_sum;

    always_comb
    begin
        cmp_sum = {1'b0, cmp_reg} + (CW+1)'(ctl.cmp_add);
        cpy_sum = {1'b0, cpy_reg} + (ctl.copy_add ? (CW+1)'(hsoc_pkg::COPY_STEP) : '0);
        if (ctl.clear)
        begin
            cmp_next = '0;
            cpy_next = '0;
        end
        else
        begin
            cmp_next = cmp_sum[CW] ? '1 : cmp_sum[CW-1:0];
            cpy_next = cpy_sum[CW] ? '1 : cpy_sum[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg <= '0;
            cpy_reg <= '0;
        end
        else
        begin
            cmp_reg <= cmp_next;
            cpy_reg <= cpy_next;
        end
    end

    assign compare_total = cmp_reg;
    assign copy_total    = cpy_reg;

endmodule

`default_nettype wire

FILE: rtl/hsoc_seq.sv
// Load, heap build, extract and emit sequencer driving the element store.
// Depends on hsoc_pkg for types, state codes and widths.
`default_nettype none

module hsoc_seq #(
    parameter int MAX_ELEMENTS = hsoc_pkg::MAX_ELEMENTS_DEF,
    parameter int AW           = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire hsoc_pkg::hsoc_in_t                item,
    output logic                                   busy,
    output logic                                   we,
    output logic [AW-1:0]                          waddr,
    output logic signed [hsoc_pkg::VALUE_W-1:0]    wdata,
    output logic                                   re,
    output logic [AW-1:0]                          raddr,
    input  wire logic signed [hsoc_pkg::VALUE_W-1:0] rdata,
    output hsoc_pkg::hsoc_cnt_ctl_t                cnt_ctl,
    output logic                                   emit_valid,
    output logic                                   emit_last
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int KW = AW + 2;
    localparam int VW = hsoc_pkg::VALUE_W;

    hsoc_pkg::hsoc_state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [AW-1:0]        p_reg, p_next;
    logic [AW-1:0]        node_reg, node_next;
    logic [AW-1:0]        j_reg, j_next;
    logic [AW-1:0]        k_reg, k_next;
    logic                 extract_reg, extract_next;
    logic signed [VW-1:0] v_reg, v_next;
    logic signed [VW-1:0] l_reg, l_next;
    logic signed [VW-1:0] tmp_reg, tmp_next;
    logic                 emit_valid_reg, emit_valid_next;
    logic                 emit_last_reg, emit_last_next;

    logic [KW-1:0]        lc, rc, len_k;
    logic                 has_l, has_r, big_l, big_r;
    logic signed [VW-1:0] top_val;
    logic                 room;
    logic [CW-1:0]        n_load, n_half;

    always_comb
    begin
        lc      = {1'b0, p_reg, 1'b1};
        rc      = KW'({p_reg, 1'b0}) + KW'(2);
        len_k   = KW'(len_reg);
        has_l   = lc < len_k;
        has_r   = rc < len_k;
        big_l   = l_reg > v_reg;
        top_val = big_l ? l_reg : v_reg;
        big_r   = has_r && (rdata > top_val);
        room    = count_reg < CW'(MAX_ELEMENTS);
        n_load  = count_reg + CW'(room);
        n_half  = n_load >> 1;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        len_next        = len_reg;
        p_next          = p_reg;
        node_next       = node_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        extract_next    = extract_reg;
        v_next          = v_reg;
        l_next          = l_reg;
        tmp_next        = tmp_reg;
        emit_valid_next = 1'b0;
        emit_last_next  = 1'b0;
        we              = 1'b0;
        waddr           = p_reg;
        wdata           = v_reg;
        re              = 1'b0;
        raddr           = p_reg;
        cnt_ctl         = '0;
        busy            = state_reg != hsoc_pkg::ST_IDLE;

        unique case (state_reg)
            hsoc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (room)
                    begin
                        we    = 1'b1;
                        waddr = count_reg[AW-1:0];
                        wdata = item.value;
                    end
                    count_next = n_load;
                    if (item.last)
                    begin
                        count_next    = '0;
                        n_next        = n_load;
                        cnt_ctl.clear = 1'b1;
                        if (n_half != '0)
                        begin
                            node_next  = AW'(n_half - CW'(1));
                            state_next = hsoc_pkg::ST_BLD_RD;
                        end
                        else
                        begin
                            j_next     = AW'(n_load - CW'(1));
                            state_next = hsoc_pkg::ST_EXT_RD0;
                        end
                    end
                end
            end
            hsoc_pkg::ST_BLD_RD:
            begin
                re           = 1'b1;
                raddr        = node_reg;
                p_next       = node_reg;
                len_next     = n_reg;
                extract_next = 1'b0;
                state_next   = hsoc_pkg::ST_BLD_WAIT;
            end
            hsoc_pkg::ST_BLD_WAIT:
            begin
                v_next     = rdata;
                state_next = hsoc_pkg::ST_SFT_L;
            end
            hsoc_pkg::ST_SFT_L:
            begin
                if (has_l)
                begin
                    re         = 1'b1;
                    raddr      = lc[AW-1:0];
                    state_next = hsoc_pkg::ST_SFT_R;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = hsoc_pkg::ST_SFT_END;
                end
            end
            hsoc_pkg::ST_SFT_R:
            begin
                l_next     = rdata;
                re         = has_r;
                raddr      = rc[AW-1:0];
                state_next = hsoc_pkg::ST_SFT_CMP;
            end
            hsoc_pkg::ST_SFT_CMP:
            begin
                cnt_ctl.cmp_add = has_r ? 2'd2 : 2'd1;
                we              = 1'b1;
                // hole method: the sifted value is written once at its final place
                if (big_r)
                begin
                    wdata            = rdata;
                    p_next           = rc[AW-1:0];
                    cnt_ctl.copy_add = 1'b1;
                    state_next       = hsoc_pkg::ST_SFT_L;
                end
                else if (big_l)
                begin
                    wdata            = l_reg;
                    p_next           = lc[AW-1:0];
                    cnt_ctl.copy_add = 1'b1;
                    state_next       = hsoc_pkg::ST_SFT_L;
                end
                else
                begin
                    state_next = hsoc_pkg::ST_SFT_END;
                end
            end
            hsoc_pkg::ST_SFT_END:
            begin
                if (!extract_reg)
                begin
                    if (node_reg == '0)
                    begin
                        j_next     = AW'(n_reg - CW'(1));
                        state_next = hsoc_pkg::ST_EXT_RD0;
                    end
                    else
                    begin
                        node_next  = node_reg - AW'(1);
                        state_next = hsoc_pkg::ST_BLD_RD;
                    end
                end
                else if (j_reg == '0)
                begin
                    k_next     = '0;
                    state_next = hsoc_pkg::ST_EMIT;
                end
                else
                begin
                    j_next     = j_reg - AW'(1);
                    state_next = hsoc_pkg::ST_EXT_RD0;
                end
            end
            hsoc_pkg::ST_EXT_RD0:
            begin
                re         = 1'b1;
                raddr      = '0;
                state_next = hsoc_pkg::ST_EXT_RDJ;
            end
            hsoc_pkg::ST_EXT_RDJ:
            begin
                re         = 1'b1;
                raddr      = j_reg;
                tmp_next   = rdata;
                state_next = hsoc_pkg::ST_EXT_WR;
            end
            hsoc_pkg::ST_EXT_WR:
            begin
                we               = 1'b1;
                waddr            = j_reg;
                wdata            = tmp_reg;
                v_next           = rdata;
                cnt_ctl.copy_add = 1'b1;
                p_next           = '0;
                len_next         = CW'(j_reg);
                extract_next     = 1'b1;
                state_next       = hsoc_pkg::ST_SFT_L;
            end
            hsoc_pkg::ST_EMIT:
            begin
                re              = 1'b1;
                raddr           = k_reg;
                emit_valid_next = 1'b1;
                k_next          = k_reg + AW'(1);
                if (CW'(k_reg) == n_reg - CW'(1))
                begin
                    emit_last_next = 1'b1;
                    state_next     = hsoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hsoc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hsoc_pkg::ST_IDLE;
            count_reg      <= '0;
            emit_valid_reg <= 1'b0;
            emit_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            emit_valid_reg <= emit_valid_next;
            emit_last_reg  <= emit_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        len_reg     <= len_next;
        p_reg       <= p_next;
        node_reg    <= node_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        extract_reg <= extract_next;
        v_reg       <= v_next;
        l_reg       <= l_next;
        tmp_reg     <= tmp_next;
    end

    assign emit_valid = emit_valid_reg;
    assign emit_last  = emit_last_reg;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for heap_sort_with_op_counts_top: loads sets, checks the
// ascending results and the comparison/copy counts against a local heap sort model.
// Depends on hsoc_pkg and the rtl under rtl/.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W    = hsoc_pkg::VALUE_W;
    localparam int COUNT_W    = hsoc_pkg::COUNT_W;
    localparam int COPY_STEP  = hsoc_pkg::COPY_STEP;
    localparam int DEPTH      = hsoc_pkg::MAX_ELEMENTS_DEF;
    localparam int PLAN_LEN   = 20;
    localparam int RAND_ITEMS = 460;
    localparam int SETTLE     = 40;
    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        hsoc_pkg::hsoc_in_t  req;
        logic [1:0]          typed_n;
        hsoc_pkg::hsoc_out_t exp_a;
        hsoc_pkg::hsoc_out_t exp_b;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    hsoc_pkg::hsoc_in_t  item;
    logic                strobe;
    hsoc_pkg::hsoc_out_t result;

    logic signed [VALUE_W-1:0] held [0:DEPTH-1];
    int                        held_n;
    int                        cmp_tally;
    int                        copy_tally;
    hsoc_pkg::hsoc_out_t       sorted_q [$];
    int                        fail_count;

    heap_sort_with_op_counts_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic hsoc_pkg::hsoc_in_t mk_req(logic signed [VALUE_W-1:0] v, logic l);
        hsoc_pkg::hsoc_in_t r;
        r.value = v;
        r.last  = l;
        return r;
    endfunction

    function automatic hsoc_pkg::hsoc_out_t mk_res(logic signed [VALUE_W-1:0] v, logic l,
                                                   int c, int p);
        hsoc_pkg::hsoc_out_t o;
        o.sorted_value  = v;
        o.last_out      = l;
        o.compare_total = c[COUNT_W-1:0];
        o.copy_total    = p[COUNT_W-1:0];
        return o;
    endfunction

    function automatic void queue_result(hsoc_pkg::hsoc_out_t o);
        sorted_q.insert(sorted_q.size(), o);
    endfunction

    function automatic void swap_held(int a, int b);
        logic signed [VALUE_W-1:0] t;
        t       = held[a];
        held[a] = held[b];
        held[b] = t;
        copy_tally = (copy_tally + COPY_STEP > 65535) ? 65535 : copy_tally + COPY_STEP;
    endfunction

    function automatic void sift_held(int len, int node);
        int  top;
        int  lc;
        int  rc;
        bit  done;
        done = 1'b0;
        while (!done)
        begin
            top = node;
            lc  = 2 * node + 1;
            rc  = 2 * node + 2;
            if (lc < len)
            begin
                cmp_tally = (cmp_tally == 65535) ? 65535 : cmp_tally + 1;
                if (held[lc] > held[top])
                    top = lc;
            end
            if (rc < len)
            begin
                cmp_tally = (cmp_tally == 65535) ? 65535 : cmp_tally + 1;
                if (held[rc] > held[top])
                    top = rc;
            end
            if (top == node)
                done = 1'b1;
            else
            begin
                swap_held(node, top);
                node = top;
            end
        end
    endfunction

    function automatic void heap_sort_held(int n);
        int i;
        cmp_tally  = 0;
        copy_tally = 0;
        for (i = n / 2; i > 0; i--)
            sift_held(n, i - 1);
        for (i = n; i > 0; i--)
        begin
            swap_held(0, i - 1);
            sift_held(i - 1, 0);
        end
    endfunction

    // store the request; a last request sorts the whole set and queues it when queue_it is set
    function automatic void predict_sorted(hsoc_pkg::hsoc_in_t r, bit queue_it);
        int k;
        if (held_n < DEPTH)
        begin
            held[held_n] = r.value;
            held_n++;
        end
        if (r.last)
        begin
            heap_sort_held(held_n);
            if (queue_it)
                for (k = 0; k < held_n; k++)
                    queue_result(mk_res(held[k], k == held_n - 1,
                                        cmp_tally, copy_tally));
            held_n = 0;
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return V_MIN;
            1: return V_MAX;
            2: return int'($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // entered and left at a falling edge with nothing yet driven in that step
    task automatic send_req(hsoc_pkg::hsoc_in_t r, int gap, bit queue_it);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_sorted(r, queue_it);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sorted_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : watch
        hsoc_pkg::hsoc_out_t want;
        if (rst_n && strobe)
        begin
            if (sorted_q.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d", result.sorted_value);
                fail_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (result.sorted_value !== want.sorted_value)
                begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, result.sorted_value);
                    fail_count++;
                end
                if (result.last_out !== want.last_out)
                begin
                    $error("last_out: expected %0d, got %0d",
                           want.last_out, result.last_out);
                    fail_count++;
                end
                if (result.compare_total !== want.compare_total)
                begin
                    $error("compare_total: expected %0d, got %0d",
                           want.compare_total, result.compare_total);
                    fail_count++;
                end
                if (result.copy_total !== want.copy_total)
                begin
                    $error("copy_total: expected %0d, got %0d",
                           want.copy_total, result.copy_total);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t plan [0:PLAN_LEN-1];
        int        sent;
        int        set_len;
        int        k;
        bit        calm;

        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        held_n     = 0;
        cmp_tally  = 0;
        copy_tally = 0;
        fail_count = 0;
        sent       = 0;

        // single sets, two-element sets with known counts, then three mixed sets
        plan[0]  = '{mk_req(V_MIN, 1'b1), 2'd1, mk_res(V_MIN, 1'b1, 0, 4), '0};
        plan[1]  = '{mk_req(V_MAX, 1'b1), 2'd1, mk_res(V_MAX, 1'b1, 0, 4), '0};
        plan[2]  = '{mk_req(0, 1'b1), 2'd1, mk_res(0, 1'b1, 0, 4), '0};
        plan[3]  = '{mk_req(V_MAX, 1'b0), 2'd0, '0, '0};
        plan[4]  = '{mk_req(V_MIN, 1'b1), 2'd2, mk_res(V_MIN, 1'b0, 1, 8),
                     mk_res(V_MAX, 1'b1, 1, 8)};
        plan[5]  = '{mk_req(V_MIN, 1'b0), 2'd0, '0, '0};
        plan[6]  = '{mk_req(V_MAX, 1'b1), 2'd2, mk_res(V_MIN, 1'b0, 1, 12),
                     mk_res(V_MAX, 1'b1, 1, 12)};
        plan[7]  = '{mk_req(-1, 1'b0), 2'd0, '0, '0};
        plan[8]  = '{mk_req(-1, 1'b1), 2'd2, mk_res(-1, 1'b0, 1, 8),
                     mk_res(-1, 1'b1, 1, 8)};
        plan[9]  = '{mk_req(-5, 1'b0), 2'd0, '0, '0};
        plan[10] = '{mk_req(3, 1'b0), 2'd0, '0, '0};
        plan[11] = '{mk_req(32'sh8000_0001, 1'b0), 2'd0, '0, '0};
        plan[12] = '{mk_req(7, 1'b0), 2'd0, '0, '0};
        plan[13] = '{mk_req(-5, 1'b1), 2'd0, '0, '0};
        plan[14] = '{mk_req(1, 1'b0), 2'd0, '0, '0};
        plan[15] = '{mk_req(2, 1'b0), 2'd0, '0, '0};
        plan[16] = '{mk_req(3, 1'b1), 2'd0, '0, '0};
        plan[17] = '{mk_req(3, 1'b0), 2'd0, '0, '0};
        plan[18] = '{mk_req(2, 1'b0), 2'd0, '0, '0};
        plan[19] = '{mk_req(1, 1'b1), 2'd0, '0, '0};

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < PLAN_LEN; k++)
        begin
            send_req(plan[k].req, $urandom_range(0, 17), plan[k].typed_n == 0);
            if (plan[k].typed_n != 0)
                queue_result(plan[k].exp_a);
            if (plan[k].typed_n == 2)
                queue_result(plan[k].exp_b);
        end

        drain_results();

        // mostly short sets; now and then a full store with up to four dropped extras
        while (sent < RAND_ITEMS)
        begin
            set_len = ($urandom_range(0, 19) == 0) ? $urandom_range(DEPTH, DEPTH + 4)
                                                   : $urandom_range(1, 12);
            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < set_len; k++)
            begin
                send_req(mk_req(pick_value(), k == set_len - 1),
                         calm ? 0 : $urandom_range(0, 17), 1'b1);
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        drain_results();

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/hsoc_pkg.sv
rtl/hsoc_store.sv
rtl/hsoc_counts.sv
rtl/hsoc_seq.sv
rtl/heap_sort_with_op_counts_top.sv
tb/tb_top.sv
